// ----- hw/rtl/hex_world_to_cell_unit_defines.svh -----
// assertion macros for the hex world-to-cell unit
// expects clk and rst_n in the scope where the macros are used
`ifndef HEX_WORLD_TO_CELL_UNIT_DEFINES_SVH
`define HEX_WORLD_TO_CELL_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define HWC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HWC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hwc_pkg.sv -----
// shared types and constants for the hex world-to-cell unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hwc_pkg;

  localparam int COORD_W   = 24;
  localparam int CELL_W    = 16;
  localparam int SIZE_W    = 16;
  localparam int DIVISOR_W = SIZE_W + 2;

  // sqrt(3)/3 with 32 fraction bits
  localparam logic [31:0] SQRT3_DIV3_Q32 = 32'h93CD_3A2C;

  localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 16'd256;

  localparam logic signed [CELL_W-1:0] CELL_MAX = 16'sh7FFF;
  localparam logic signed [CELL_W-1:0] CELL_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
  } hwc_in_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_col;
    logic signed [CELL_W-1:0] cell_row;
    logic                     out_of_range;
  } hwc_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hwc_front.sv -----
// front end: builds the two fixed-point numerators from a world point
// three pipeline stages; uses hwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hwc_front import hwc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int NUM_W = 27 + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hwc_in_t                 in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NUM_W-1:0] out_num_x,
  output logic signed [NUM_W-1:0] out_num_z
);

  localparam int X3_W   = COORD_W + 2;
  localparam int PROD_W = X3_W + 33;

  logic va_r, vb_r, vc_r;
  logic ready_a, ready_b, ready_c;

  logic signed [X3_W-1:0]    x3_nxt, a_x3_r;
  logic signed [COORD_W-1:0] a_y_r, b_y_r;
  logic signed [32:0]        k_s;
  logic signed [PROD_W-1:0]  prod_nxt, b_prod_r;
  logic signed [PROD_W-1:0]  y_sh, nx_full;
  logic signed [NUM_W-1:0]   nx_nxt, nz_nxt, c_nx_r, c_nz_r;

  assign ready_c  = !vc_r || out_ready;
  assign ready_b  = !vb_r || ready_c;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  // stage a: 3*x
  assign x3_nxt = X3_W'($signed(in_item.world_x))
                + (X3_W'($signed(in_item.world_x)) <<< 1);

  // stage b: 3*x*K, a 26 by 33 bit signed product
  assign k_s      = $signed({1'b0, SQRT3_DIV3_Q32});
  assign prod_nxt = PROD_W'(a_x3_r) * PROD_W'(k_s);

  // stage c: subtract y*2^32, scale down, and build the z numerator
  assign y_sh    = PROD_W'(b_y_r) <<< 32;
  assign nx_full = b_prod_r - y_sh;
  assign nx_nxt  = $signed(nx_full[PROD_W-1:32-FRAC_BITS]);
  assign nz_nxt  = NUM_W'(b_y_r) <<< (FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= in_valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
      if (ready_c) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      a_x3_r <= x3_nxt;
      a_y_r  <= $signed(in_item.world_y);
    end
    if (ready_b && va_r) begin
      b_prod_r <= prod_nxt;
      b_y_r    <= a_y_r;
    end
    if (ready_c && vb_r) begin
      c_nx_r <= nx_nxt;
      c_nz_r <= nz_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_num_x = c_nx_r;
  assign out_num_z = c_nz_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hwc_div.sv -----
// pipelined restoring divider, two lanes sharing one divisor, floor semantics
// DIV_STEPS quotient bits per stage; uses hwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hwc_div import hwc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int DIV_STEPS = 4,
  localparam int NUM_W = 27 + FRAC_BITS,
  localparam int QUO_W = NUM_W + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [NUM_W-1:0] in_num_x,
  input  logic signed [NUM_W-1:0] in_num_z,
  input  logic [DIVISOR_W-1:0]    divisor,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [QUO_W-1:0] out_quo_x,
  output logic signed [QUO_W-1:0] out_quo_z
);

  localparam int NSTG = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef struct packed {
    logic                 neg;
    logic [DIVISOR_W-1:0] rem;
    logic [NUM_W-1:0]     work;
  } lane_t;

  // one restoring step: quotient bits shift into the low end of work
  function automatic lane_t div_step(input lane_t l, input logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W:0] t;
    logic               ge;
    lane_t              o;
    t      = {l.rem, l.work[NUM_W-1]};
    ge     = (t >= {1'b0, d});
    o      = l;
    o.rem  = ge ? DIVISOR_W'(t - {1'b0, d}) : t[DIVISOR_W-1:0];
    o.work = {l.work[NUM_W-2:0], ge};
    return o;
  endfunction

  // floor correction for negative numerators
  function automatic logic signed [QUO_W-1:0] fix_sign(input lane_t l);
    logic signed [QUO_W-1:0] m;
    m = $signed({1'b0, l.work});
    if (l.neg) begin
      return -m - $signed({{(QUO_W-1){1'b0}}, |l.rem});
    end
    return m;
  endfunction

  lane_t x_r [0:NSTG];
  lane_t z_r [0:NSTG];
  logic  v_r [0:NSTG];
  logic  rdy [0:NSTG+1];

  lane_t x0_nxt, z0_nxt;

  logic                    fv_r;
  logic signed [QUO_W-1:0] qx_r, qz_r;

  assign rdy[NSTG+1] = !fv_r || out_ready;

  for (genvar s = 0; s <= NSTG; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end

  assign in_ready = rdy[0];

  // stage 0: sign and magnitude
  always_comb begin
    x0_nxt.neg  = in_num_x[NUM_W-1];
    x0_nxt.rem  = '0;
    x0_nxt.work = in_num_x[NUM_W-1] ? NUM_W'(-in_num_x) : NUM_W'(in_num_x);
    z0_nxt.neg  = in_num_z[NUM_W-1];
    z0_nxt.rem  = '0;
    z0_nxt.work = in_num_z[NUM_W-1] ? NUM_W'(-in_num_z) : NUM_W'(in_num_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      x_r[0] <= x0_nxt;
      z_r[0] <= z0_nxt;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_stage
    lane_t lx, lz;

    always_comb begin
      lx = x_r[s-1];
      lz = z_r[s-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        // the last stage may have fewer live steps
        if ((s - 1) * DIV_STEPS + j < NUM_W) begin
          lx = div_step(lx, divisor);
          lz = div_step(lz, divisor);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_r[s-1]) begin
        x_r[s] <= lx;
        z_r[s] <= lz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (rdy[NSTG+1]) begin
      fv_r <= v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG+1] && v_r[NSTG]) begin
      qx_r <= fix_sign(x_r[NSTG]);
      qz_r <= fix_sign(z_r[NSTG]);
    end
  end

  assign out_valid = fv_r;
  assign out_quo_x = qx_r;
  assign out_quo_z = qz_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hwc_round.sv -----
// cube rounding, largest-error rebuild, offset conversion and saturation
// four pipeline stages, the last one is the output register; uses hwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hwc_round import hwc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int QUO_W = 28 + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [QUO_W-1:0] in_quo_x,
  input  logic signed [QUO_W-1:0] in_quo_z,
  input  logic                    size_zero,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hwc_out_t                out_item
);

  localparam int EXT_W = QUO_W + 2;
  localparam int RND_W = EXT_W - FRAC_BITS;
  localparam int BLD_W = RND_W + 2;
  localparam int COL_W = BLD_W + 1;

  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // distance of the rounded value from the original, from the low bits of q + half
  function automatic logic [FRAC_BITS-1:0] round_err(input logic [FRAC_BITS-1:0] low);
    logic [FRAC_BITS:0] d;
    d = {1'b0, HALF} - {1'b0, low};
    return d[FRAC_BITS] ? FRAC_BITS'(-d) : d[FRAC_BITS-1:0];
  endfunction

  // returns {saturated, clamped value}
  function automatic logic [CELL_W:0] clamp(input logic signed [COL_W-1:0] v);
    logic fits;
    fits = (&v[COL_W-1:CELL_W-1]) || !(|v[COL_W-1:CELL_W-1]);
    if (fits) begin
      return {1'b0, v[CELL_W-1:0]};
    end
    return {1'b1, v[COL_W-1] ? CELL_MIN : CELL_MAX};
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [EXT_W-1:0] qy_nxt;
  logic signed [EXT_W-1:0] s1_qx_r, s1_qy_r, s1_qz_r;

  logic signed [EXT_W-1:0]  tx, ty, tz;
  logic signed [RND_W-1:0]  s2_rx_r, s2_ry_r, s2_rz_r;
  logic [FRAC_BITS-1:0]     s2_ex_r, s2_ey_r, s2_ez_r;

  logic signed [BLD_W-1:0]  bx, by, bz;
  logic signed [BLD_W-1:0]  s3_rx_r, s3_rz_r;

  logic signed [COL_W-1:0]  col_full, row_full;
  logic [CELL_W:0]          col_c, row_c;
  hwc_out_t                 res_nxt, res_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: y = -x - z
  assign qy_nxt = -EXT_W'(in_quo_x) - EXT_W'(in_quo_z);

  // stage 2: round half up and rounding error per component
  assign tx = s1_qx_r + $signed({{(EXT_W-FRAC_BITS){1'b0}}, HALF});
  assign ty = s1_qy_r + $signed({{(EXT_W-FRAC_BITS){1'b0}}, HALF});
  assign tz = s1_qz_r + $signed({{(EXT_W-FRAC_BITS){1'b0}}, HALF});

  // stage 3: rebuild the component with the largest error
  always_comb begin
    bx = BLD_W'(s2_rx_r);
    by = BLD_W'(s2_ry_r);
    bz = BLD_W'(s2_rz_r);
    if (s2_ex_r > s2_ey_r && s2_ex_r > s2_ez_r) begin
      bx = -by - bz;
    end else if (s2_ey_r > s2_ez_r) begin
      by = -bx - bz;
    end else begin
      bz = -bx - by;
    end
  end

  // stage 4: odd-row offset and clamp; (z - (z & 1)) / 2 is z >>> 1
  assign col_full = COL_W'(s3_rx_r) + COL_W'(s3_rz_r >>> 1);
  assign row_full = COL_W'(s3_rz_r);
  assign col_c    = clamp(col_full);
  assign row_c    = clamp(row_full);

  always_comb begin
    if (size_zero) begin
      res_nxt.cell_col     = '0;
      res_nxt.cell_row     = '0;
      res_nxt.out_of_range = 1'b1;
    end else begin
      res_nxt.cell_col     = $signed(col_c[CELL_W-1:0]);
      res_nxt.cell_row     = $signed(row_c[CELL_W-1:0]);
      res_nxt.out_of_range = col_c[CELL_W] || row_c[CELL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_qx_r <= EXT_W'(in_quo_x);
      s1_qy_r <= qy_nxt;
      s1_qz_r <= EXT_W'(in_quo_z);
    end
    if (rdy2 && v1_r) begin
      s2_rx_r <= $signed(tx[EXT_W-1:FRAC_BITS]);
      s2_ry_r <= $signed(ty[EXT_W-1:FRAC_BITS]);
      s2_rz_r <= $signed(tz[EXT_W-1:FRAC_BITS]);
      s2_ex_r <= round_err(tx[FRAC_BITS-1:0]);
      s2_ey_r <= round_err(ty[FRAC_BITS-1:0]);
      s2_ez_r <= round_err(tz[FRAC_BITS-1:0]);
    end
    if (rdy3 && v2_r) begin
      s3_rx_r <= bx;
      s3_rz_r <= bz;
    end
    if (rdy4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hex_world_to_cell_unit.sv -----
// Throughput: one item per cycle while out_stall is low; the divider pipeline takes DIV_STEPS
// quotient bits per stage and sets the depth, every stage has its own valid bit.
// Reset (synchronous, rst_n low) empties the pipeline and loads cell size 256.
// Top level: cell size register, numerator front end, divider, rounding back end;
// uses hwc_pkg and hex_world_to_cell_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "hex_world_to_cell_unit_defines.svh"

module hex_world_to_cell_unit import hwc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int DIV_STEPS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  hwc_in_t           in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hwc_out_t          out_item
);

  localparam int NUM_W = 27 + FRAC_BITS;
  localparam int QUO_W = NUM_W + 1;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = DIVISOR_W'(3 * CELL_SIZE_RST);

  logic [SIZE_W-1:0]    size_r;
  logic [DIVISOR_W-1:0] divisor_r;
  logic                 size_zero_r;

  logic                    fe_in_ready, fe_valid, div_in_ready;
  logic signed [NUM_W-1:0] num_x, num_z;
  logic                    div_valid, rnd_in_ready;
  logic signed [QUO_W-1:0] quo_x, quo_z;

  // divisor kept as 3 * cell size so the divider sees a ready operand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= CELL_SIZE_RST;
      divisor_r   <= DIVISOR_RST;
      size_zero_r <= 1'b0;
    end else if (cfg_wr_en) begin
      size_r      <= cfg_wr_data;
      divisor_r   <= DIVISOR_W'(cfg_wr_data) + (DIVISOR_W'(cfg_wr_data) << 1);
      size_zero_r <= (cfg_wr_data == '0);
    end
  end

  hwc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (fe_in_ready),
    .in_item   (in_item),
    .out_valid (fe_valid),
    .out_ready (div_in_ready),
    .out_num_x (num_x),
    .out_num_z (num_z)
  );

  hwc_div #(
    .FRAC_BITS (FRAC_BITS),
    .DIV_STEPS (DIV_STEPS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (div_in_ready),
    .in_num_x  (num_x),
    .in_num_z  (num_z),
    .divisor   (divisor_r),
    .out_valid (div_valid),
    .out_ready (rnd_in_ready),
    .out_quo_x (quo_x),
    .out_quo_z (quo_z)
  );

  hwc_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (rnd_in_ready),
    .in_quo_x  (quo_x),
    .in_quo_z  (quo_z),
    .size_zero (size_zero_r),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_item  (out_item)
  );

  assign in_stall = !fe_in_ready;

  // the input can only back up when the output is holding a stalled item
  `HWC_ASSERT_IMPL(a_stall_from_output, in_stall, out_valid && out_stall, "input stalled with output free")
  `HWC_ASSERT_ALWAYS(a_divisor_track, divisor_r == (DIVISOR_W'(size_r) + (DIVISOR_W'(size_r) << 1)), "divisor out of step with cell size")
  `HWC_ASSERT_ALWAYS(a_zero_track, size_zero_r == (size_r == '0), "zero flag out of step with cell size")

endmodule

`default_nettype wire
